>>> rtl/tlik_pkg.sv
package tlik_pkg;

  localparam int XW    = 24;   // target coordinate width, signed Q8.16
  localparam int LW    = 23;   // link length width, unsigned Q7.16
  localparam int SHW   = 23;   // shoulder angle width, signed Q3.20
  localparam int ELW   = 22;   // elbow angle width, unsigned Q2.20
  localparam int DENW  = 48;   // 2*L1*L2
  localparam int NUMW  = 49;   // law-of-cosines numerator and divider remainder
  localparam int QW    = 31;   // |cos2| in Q.30
  localparam int CSW   = 32;   // signed cos2 in Q2.30
  localparam int RADW  = 62;   // radicand of the sine, padded to an even width
  localparam int REMW  = 34;   // square root partial remainder
  localparam int KW    = 40;   // K1 and K2 in Q.30
  localparam int PW    = 64;   // shoulder vector components
  localparam int CW    = 44;   // CORDIC x and y
  localparam int ZW    = 35;   // CORDIC angle accumulator, Q.30 radians

  localparam int DIV_CELLS  = QW - 1;
  localparam int SQRT_CELLS = RADW / 2;
  localparam int NORM_CELLS = 24;
  // Register stages outside the CORDIC chain, from the input to the outputs.
  localparam int PIPE_FIXED = DIV_CELLS + SQRT_CELLS + NORM_CELLS + 9;

  localparam logic [0:0] REG_L1 = 1'b0;
  localparam logic [0:0] REG_L2 = 1'b1;

  localparam logic [RADW-1:0]    ONE_SQ    = RADW'(62'h1000_0000_0000_0000);
  localparam logic signed [PW-1:0] NORM_LIM  = 64'sh0000_0100_0000_0000;
  localparam logic signed [PW-1:0] NORM_NLIM = -64'sh0000_0100_0000_0000;
  localparam logic signed [ZW-1:0] PI_Q30    = 35'sd3373259426;
  localparam logic signed [ZW-1:0] NPI_Q30   = -35'sd3373259426;
  localparam logic signed [25:0]   ANG_MAX   = 26'sd3294199;
  localparam logic signed [25:0]   ANG_NMAX  = -26'sd3294199;

  typedef struct packed {
    logic                   reach;
    logic                   neg;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [CSW-1:0]  c;
    logic [QW-1:0]          s;
  } side_t;

  typedef struct packed {
    logic reach;
    logic zero;
  } cflag_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 35'sd843314857;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043837;
      3:  a = 35'sd133525159;
      4:  a = 35'sd67021687;
      5:  a = 35'sd33543516;
      6:  a = 35'sd16775851;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194283;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048576;
      11: a = 35'sd524288;
      12: a = 35'sd262144;
      13: a = 35'sd131072;
      14: a = 35'sd65536;
      15: a = 35'sd32768;
      16: a = 35'sd16384;
      17: a = 35'sd8192;
      18: a = 35'sd4096;
      19: a = 35'sd2048;
      20: a = 35'sd1024;
      21: a = 35'sd512;
      22: a = 35'sd256;
      23: a = 35'sd128;
      24: a = 35'sd64;
      25: a = 35'sd32;
      26: a = 35'sd16;
      27: a = 35'sd8;
      28: a = 35'sd4;
      29: a = 35'sd2;
      30: a = 35'sd1;
      default: a = 35'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/tlik_div_cell.sv
module tlik_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tlik_pkg::DENW-1:0]     den,
  input  logic                          valid_in,
  input  tlik_pkg::side_t               side_in,
  input  logic [tlik_pkg::NUMW-1:0]     rem_in,
  input  logic [tlik_pkg::QW-1:0]       quo_in,
  output logic                          valid_out,
  output tlik_pkg::side_t               side_out,
  output logic [tlik_pkg::NUMW-1:0]     rem_out,
  output logic [tlik_pkg::QW-1:0]       quo_out
);
  import tlik_pkg::*;

  logic [NUMW-1:0] rem_sh;
  logic            ge;
  logic            valid_r;
  side_t           side_r;
  logic [NUMW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;

  // One restoring division step: shift in a zero, subtract the divisor if it fits.
  always_comb begin
    rem_sh  = {rem_in[NUMW-2:0], 1'b0};
    ge      = rem_sh >= {1'b0, den};
    rem_nxt = ge ? rem_sh - {1'b0, den} : rem_sh;
    quo_nxt = {quo_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    side_r <= side_in;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign valid_out = valid_r;
  assign side_out  = side_r;
  assign rem_out   = rem_r;
  assign quo_out   = quo_r;
endmodule

>>> rtl/tlik_sqrt_cell.sv
module tlik_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  tlik_pkg::side_t               side_in,
  input  logic [tlik_pkg::RADW-1:0]     rad_in,
  input  logic [tlik_pkg::QW-1:0]       res_in,
  input  logic [tlik_pkg::REMW-1:0]     rem_in,
  output logic                          valid_out,
  output tlik_pkg::side_t               side_out,
  output logic [tlik_pkg::RADW-1:0]     rad_out,
  output logic [tlik_pkg::QW-1:0]       res_out,
  output logic [tlik_pkg::REMW-1:0]     rem_out
);
  import tlik_pkg::*;

  logic [REMW-1:0] rem_t, trial;
  logic            ge;
  logic            valid_r;
  side_t           side_r;
  logic [RADW-1:0] rad_r;
  logic [QW-1:0]   res_r, res_nxt;
  logic [REMW-1:0] rem_r, rem_nxt;

  // One result bit per cell: bring down the next two radicand bits and try 4*res+1.
  always_comb begin
    rem_t   = {rem_in[REMW-3:0], rad_in[RADW-1:RADW-2]};
    trial   = REMW'({res_in, 2'b01});
    ge      = rem_t >= trial;
    rem_nxt = ge ? rem_t - trial : rem_t;
    res_nxt = {res_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    side_r <= side_in;
    rad_r  <= {rad_in[RADW-3:0], 2'b00};
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
  end

  assign valid_out = valid_r;
  assign side_out  = side_r;
  assign rad_out   = rad_r;
  assign res_out   = res_r;
  assign rem_out   = rem_r;
endmodule

>>> rtl/tlik_norm_cell.sv
module tlik_norm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  tlik_pkg::side_t               side_in,
  input  logic signed [tlik_pkg::PW-1:0] px_in,
  input  logic signed [tlik_pkg::PW-1:0] py_in,
  output logic                          valid_out,
  output tlik_pkg::side_t               side_out,
  output logic signed [tlik_pkg::PW-1:0] px_out,
  output logic signed [tlik_pkg::PW-1:0] py_out
);
  import tlik_pkg::*;

  logic                 big;
  logic                 valid_r;
  side_t                side_r;
  logic signed [PW-1:0] px_r, py_r;

  // Halve both components while either one still reaches 2^40 in magnitude.
  assign big = (px_in >= NORM_LIM) || (px_in <= NORM_NLIM) ||
               (py_in >= NORM_LIM) || (py_in <= NORM_NLIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    side_r <= side_in;
    px_r   <= big ? (px_in >>> 1) : px_in;
    py_r   <= big ? (py_in >>> 1) : py_in;
  end

  assign valid_out = valid_r;
  assign side_out  = side_r;
  assign px_out    = px_r;
  assign py_out    = py_r;
endmodule

>>> rtl/tlik_cordic_cell.sv
module tlik_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  input  tlik_pkg::cflag_t    flag_in,
  input  tlik_pkg::cvec_t     el_in,
  input  tlik_pkg::cvec_t     sh_in,
  output logic                valid_out,
  output tlik_pkg::cflag_t    flag_out,
  output tlik_pkg::cvec_t     el_out,
  output tlik_pkg::cvec_t     sh_out
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

  logic   valid_r;
  cflag_t flag_r;
  cvec_t  el_r, el_nxt, sh_r, sh_nxt;

  // Vectoring micro-rotation: steer y toward zero, y >= 0 counts as positive.
  function automatic cvec_t rotate(input cvec_t v);
    cvec_t o;
    if (v.y >= 0) begin
      o.x = v.x + (v.y >>> STAGE);
      o.y = v.y - (v.x >>> STAGE);
      o.z = v.z + ATAN;
    end else begin
      o.x = v.x - (v.y >>> STAGE);
      o.y = v.y + (v.x >>> STAGE);
      o.z = v.z - ATAN;
    end
    return o;
  endfunction

  always_comb begin
    el_nxt = rotate(el_in);
    sh_nxt = rotate(sh_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    flag_r <= flag_in;
    el_r   <= el_nxt;
    sh_r   <= sh_nxt;
  end

  assign valid_out = valid_r;
  assign flag_out  = flag_r;
  assign el_out    = el_r;
  assign sh_out    = sh_r;
endmodule

>>> rtl/two_link_inverse_kinematics.sv
// Two-link planar inverse kinematics, elbow-up solution.
//
// Requests: drive in_target_x and in_target_y (signed Q8.16) and pulse start.
// A request is taken at every rising edge with start high; busy stays low, so
// a new request may follow in every cycle. Each request yields one result:
// out_valid is high for exactly one cycle with out_shoulder_angle (signed
// Q3.20 radians), out_elbow_angle (Q2.20, 0 to pi) and out_reachable. A target
// outside the workspace, or a link length of zero, gives zero angles with
// out_reachable low. The receiver cannot hold results off and must take each
// one in its cycle.
//
// Throughput is one request per cycle. The bulk of the pipeline is the cell
// chains: 31 steps of the cosine divider, 31 steps of the sine square root,
// 24 normalizing steps and the CORDIC chain that resolves both angles side by
// side.
//
// Link lengths sit behind the APB port at byte addresses 0 and 4; both reset to
// 1.0. Write them only while no request is in flight. Reset empties the
// pipeline, so no result appears for a request that was in flight.
module two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [tlik_pkg::XW-1:0]  in_target_x,
  input  logic signed [tlik_pkg::XW-1:0]  in_target_y,
  output logic                            out_valid,
  output logic signed [tlik_pkg::SHW-1:0] out_shoulder_angle,
  output logic [tlik_pkg::ELW-1:0]        out_elbow_angle,
  output logic                            out_reachable,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tlik_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers and the constants derived from them. The derived
  // values follow a write in the next cycle; the idle rule for writes covers it.
  // ---------------------------------------------------------------------------
  logic [LW-1:0]     l1_r, l2_r;
  logic [2*LW-1:0]   l1sq_r, l2sq_r, l12;
  logic [DENW-1:0]   den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= LW'(65536);
      l2_r <= LW'(65536);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_L1:  l1_r <= pwdata[LW-1:0];
        REG_L2:  l2_r <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_L1:  prdata = {{(32-LW){1'b0}}, l1_r};
      REG_L2:  prdata = {{(32-LW){1'b0}}, l2_r};
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign l12    = l1_r * l2_r;

  always_ff @(posedge clk) begin
    l1sq_r <= l1_r * l1_r;
    l2sq_r <= l2_r * l2_r;
    den_r  <= DENW'({l12, 1'b0});
  end

  // ---------------------------------------------------------------------------
  // Stage 1: square the target coordinates.
  // ---------------------------------------------------------------------------
  logic                   v1_r;
  logic signed [XW-1:0]   x1_r, y1_r;
  logic signed [2*XW-1:0] sqx, sqy;
  logic [2*XW-2:0]        xx_r, yy_r;

  assign sqx = in_target_x * in_target_x;
  assign sqy = in_target_y * in_target_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    x1_r <= in_target_x;
    y1_r <= in_target_y;
    xx_r <= sqx[2*XW-2:0];
    yy_r <= sqy[2*XW-2:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: law-of-cosines numerator, its magnitude and the reach test.
  // ---------------------------------------------------------------------------
  logic signed [NUMW-1:0] num, num_abs;
  logic                   v2_r;
  side_t                  s2_r, s2_nxt;
  logic [DENW-1:0]        mag2_r;

  always_comb begin
    num = $signed({2'b00, xx_r}) + $signed({2'b00, yy_r})
        - $signed({3'b000, l1sq_r}) - $signed({3'b000, l2sq_r});
    num_abs      = num[NUMW-1] ? -num : num;
    s2_nxt       = '0;
    s2_nxt.x     = x1_r;
    s2_nxt.y     = y1_r;
    s2_nxt.neg   = num[NUMW-1];
    s2_nxt.reach = (den_r != '0) && (num_abs[DENW-1:0] <= den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s2_r   <= s2_nxt;
    mag2_r <= num_abs[DENW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: integer bit of |cos2|; the divider cells add the 30 fraction bits.
  // ---------------------------------------------------------------------------
  logic            v3_r, ge3;
  side_t           s3_r;
  logic [NUMW-1:0] rem3_r;
  logic [QW-1:0]   quo3_r;

  assign ge3 = mag2_r >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r   <= s2_r;
    rem3_r <= NUMW'(ge3 ? mag2_r - den_r : mag2_r);
    quo3_r <= QW'(ge3);
  end

  logic            dv [0:DIV_CELLS];
  side_t           ds [0:DIV_CELLS];
  logic [NUMW-1:0] dr [0:DIV_CELLS];
  logic [QW-1:0]   dq [0:DIV_CELLS];

  assign dv[0] = v3_r;
  assign ds[0] = s3_r;
  assign dr[0] = rem3_r;
  assign dq[0] = quo3_r;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    tlik_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .den       (den_r),
      .valid_in  (dv[g]),
      .side_in   (ds[g]),
      .rem_in    (dr[g]),
      .quo_in    (dq[g]),
      .valid_out (dv[g+1]),
      .side_out  (ds[g+1]),
      .rem_out   (dr[g+1]),
      .quo_out   (dq[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 4: signed cos2 in Q2.30 and the sine radicand 1 - cos2^2 in Q.60.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]   q_fin;
  logic [RADW-1:0] qq;
  logic            v4_r;
  side_t           s4_r, s4_nxt;
  logic [RADW-1:0] rad4_r;

  always_comb begin
    q_fin  = dq[DIV_CELLS];
    qq     = q_fin * q_fin;
    s4_nxt = ds[DIV_CELLS];
    s4_nxt.c = s4_nxt.neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dv[DIV_CELLS];
    end
    s4_r   <= s4_nxt;
    rad4_r <= ONE_SQ - qq;
  end

  logic            qv [0:SQRT_CELLS];
  side_t           qs [0:SQRT_CELLS];
  logic [RADW-1:0] qr [0:SQRT_CELLS];
  logic [QW-1:0]   qo [0:SQRT_CELLS];
  logic [REMW-1:0] qm [0:SQRT_CELLS];

  assign qv[0] = v4_r;
  assign qs[0] = s4_r;
  assign qr[0] = rad4_r;
  assign qo[0] = '0;
  assign qm[0] = '0;

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    tlik_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (qv[g]),
      .side_in   (qs[g]),
      .rad_in    (qr[g]),
      .res_in    (qo[g]),
      .rem_in    (qm[g]),
      .valid_out (qv[g+1]),
      .side_out  (qs[g+1]),
      .rad_out   (qr[g+1]),
      .res_out   (qo[g+1]),
      .rem_out   (qm[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 5: K1 = L1 + L2*cos2 and K2 = L2*sin2 in Q.30.
  // ---------------------------------------------------------------------------
  side_t                  s5_in;
  logic signed [55:0]     p1;
  logic [53:0]            p2;
  logic                   v5_r;
  side_t                  s5_r;
  logic signed [KW-1:0]   k1_r, k2_r;

  always_comb begin
    s5_in   = qs[SQRT_CELLS];
    s5_in.s = qo[SQRT_CELLS];
    p1      = $signed({1'b0, l2_r}) * s5_in.c;
    p2      = l2_r * s5_in.s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= qv[SQRT_CELLS];
    end
    s5_r <= s5_in;
    k1_r <= $signed({3'b000, l1_r, 14'b0}) + p1[55:16];
    k2_r <= $signed({2'b00, p2[53:16]});
  end

  // ---------------------------------------------------------------------------
  // Stages 6 and 7: the four cross products, then the shoulder vector.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pa, pb, pc, pd;
  logic                 v6_r, v7_r;
  side_t                s6_r, s7_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, px7_r, py7_r;

  assign pa = k1_r * s5_r.x;
  assign pb = k2_r * s5_r.y;
  assign pc = k1_r * s5_r.y;
  assign pd = k2_r * s5_r.x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    s6_r  <= s5_r;
    pa_r  <= pa;
    pb_r  <= pb;
    pc_r  <= pc;
    pd_r  <= pd;
    s7_r  <= s6_r;
    px7_r <= pa_r + pb_r;
    py7_r <= pc_r - pd_r;
  end

  logic                 nv [0:NORM_CELLS];
  side_t                ns [0:NORM_CELLS];
  logic signed [PW-1:0] nx [0:NORM_CELLS];
  logic signed [PW-1:0] ny [0:NORM_CELLS];

  assign nv[0] = v7_r;
  assign ns[0] = s7_r;
  assign nx[0] = px7_r;
  assign ny[0] = py7_r;

  for (genvar g = 0; g < NORM_CELLS; g++) begin : g_norm
    tlik_norm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (nv[g]),
      .side_in   (ns[g]),
      .px_in     (nx[g]),
      .py_in     (ny[g]),
      .valid_out (nv[g+1]),
      .side_out  (ns[g+1]),
      .px_out    (nx[g+1]),
      .py_out    (ny[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 8: CORDIC entry. A vector in the left half-plane is turned by pi so
  // the chain only sees x >= 0; the elbow vector is (cos2, sin2).
  // ---------------------------------------------------------------------------
  side_t                sn;
  logic signed [PW-1:0] pxn, pyn;
  cvec_t                el_pre, sh_pre;
  cflag_t               f_pre;
  logic                 v8_r;
  cflag_t               f8_r;
  cvec_t                el8_r, sh8_r;

  always_comb begin
    sn       = ns[NORM_CELLS];
    pxn      = nx[NORM_CELLS];
    pyn      = ny[NORM_CELLS];
    f_pre.reach = sn.reach;
    f_pre.zero  = (pxn == '0) && (pyn == '0);

    el_pre.x = CW'(sn.c);
    el_pre.y = $signed({{(CW-QW){1'b0}}, sn.s});
    el_pre.z = '0;
    if (el_pre.x < 0) begin
      el_pre.z = (el_pre.y >= 0) ? PI_Q30 : NPI_Q30;
      el_pre.x = -el_pre.x;
      el_pre.y = -el_pre.y;
    end

    sh_pre.x = pxn[CW-1:0];
    sh_pre.y = pyn[CW-1:0];
    sh_pre.z = '0;
    if (sh_pre.x < 0) begin
      sh_pre.z = (sh_pre.y >= 0) ? PI_Q30 : NPI_Q30;
      sh_pre.x = -sh_pre.x;
      sh_pre.y = -sh_pre.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= nv[NORM_CELLS];
    end
    f8_r  <= f_pre;
    el8_r <= el_pre;
    sh8_r <= sh_pre;
  end

  logic   cv [0:CORDIC_STAGES];
  cflag_t cf [0:CORDIC_STAGES];
  cvec_t  ce [0:CORDIC_STAGES];
  cvec_t  cs [0:CORDIC_STAGES];

  assign cv[0] = v8_r;
  assign cf[0] = f8_r;
  assign ce[0] = el8_r;
  assign cs[0] = sh8_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    tlik_cordic_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (cv[g]),
      .flag_in   (cf[g]),
      .el_in     (ce[g]),
      .sh_in     (cs[g]),
      .valid_out (cv[g+1]),
      .flag_out  (cf[g+1]),
      .el_out    (ce[g+1]),
      .sh_out    (cs[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: round Q.30 to Q3.20 and Q2.20, clamp, and force zero angles
  // for an unreachable target; a zero shoulder vector zeroes the shoulder only.
  // ---------------------------------------------------------------------------
  cflag_t             fo;
  logic signed [ZW:0] el_rnd, sh_rnd;
  logic signed [25:0] el_q, sh_q, el_c, sh_c;
  logic               ov_r;
  logic [SHW-1:0]     osh_r;
  logic [ELW-1:0]     oel_r;
  logic               ore_r;

  always_comb begin
    fo     = cf[CORDIC_STAGES];
    el_rnd = {ce[CORDIC_STAGES].z[ZW-1], ce[CORDIC_STAGES].z} + 36'sd512;
    sh_rnd = {cs[CORDIC_STAGES].z[ZW-1], cs[CORDIC_STAGES].z} + 36'sd512;
    el_q   = el_rnd[ZW:10];
    sh_q   = sh_rnd[ZW:10];
    el_c   = (el_q > ANG_MAX) ? ANG_MAX : ((el_q < 0) ? 26'sd0 : el_q);
    sh_c   = (sh_q > ANG_MAX) ? ANG_MAX : ((sh_q < ANG_NMAX) ? ANG_NMAX : sh_q);
    if (fo.zero) begin
      sh_c = '0;
    end
    if (!fo.reach) begin
      sh_c = '0;
      el_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cv[CORDIC_STAGES];
    end
    osh_r <= sh_c[SHW-1:0];
    oel_r <= el_c[ELW-1:0];
    ore_r <= fo.reach;
  end

  assign out_valid          = ov_r;
  assign out_shoulder_angle = $signed(osh_r);
  assign out_elbow_angle    = oel_r;
  assign out_reachable      = ore_r;
endmodule

>>> rtl/tlik_checker.sv
module tlik_checker #(
  parameter int CORDIC_STAGES = 20
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic signed [tlik_pkg::SHW-1:0] out_shoulder_angle,
  input logic [tlik_pkg::ELW-1:0]        out_elbow_angle,
  input logic                            out_reachable
);
  import tlik_pkg::*;

  localparam int LAT = PIPE_FIXED + CORDIC_STAGES;

  // A result only ever answers a request taken exactly one latency earlier.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_unreachable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_shoulder_angle == '0 && out_elbow_angle == '0)
    else $error("unreachable target with nonzero angles");

  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elbow_angle <= ELW'(3294199))
    else $error("elbow angle beyond pi");

  a_shoulder_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shoulder_angle <= 23'sd3294199 && out_shoulder_angle >= -23'sd3294199)
    else $error("shoulder angle beyond pi");
endmodule

bind two_link_inverse_kinematics tlik_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_tlik_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_shoulder_angle (out_shoulder_angle),
  .out_elbow_angle    (out_elbow_angle),
  .out_reachable      (out_reachable)
);

>>> tb/two_link_inverse_kinematics_tb.sv
module two_link_inverse_kinematics_tb;
  import tlik_pkg::*;

  // Bench parameters.
  localparam int STAGES       = 20;
  localparam int LATENCY      = 94 + STAGES;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 400000;

  // Addresses of the two link length registers.
  localparam logic [2:0] ADDR_L1 = 3'd0;
  localparam logic [2:0] ADDR_L2 = 3'd4;

  // Extremes of the Q3.20 and Q2.20 angle outputs and of the fixed-point formats.
  localparam longint ANGLE_LIMIT = 3294199;
  localparam longint PI_FIXED    = 64'sd3373259426;
  localparam longint UNIT_Q30    = 1073741824;

  // Directed requests use this code where the expected result is typed in.
  localparam int EXP_NONE = 0;
  localparam int EXP_ZERO = 1;

  // One expected joint solution.
  typedef struct {
    logic signed [SHW-1:0] shoulder;
    logic [ELW-1:0]        elbow;
    logic                  reach;
  } joint_sol_t;

  // One row of the directed table: a target and, where obvious, its answer.
  typedef struct {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    int                   typed;
  } target_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [XW-1:0]  in_target_x;
  logic signed [XW-1:0]  in_target_y;
  logic                  out_valid;
  logic signed [SHW-1:0] out_shoulder_angle;
  logic [ELW-1:0]        out_elbow_angle;
  logic                  out_reachable;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // The bench's own copy of the link lengths, updated on every register write.
  logic [LW-1:0] len_shoulder_link;
  logic [LW-1:0] len_elbow_link;

  // Solutions still owed by the block, oldest first.
  joint_sol_t pending_solutions[$];

  int fail_count;
  int cycle_count;
  int solutions_checked;
  int unreachable_seen;
  int requests_sent;
  int settings_used;

  two_link_inverse_kinematics #(
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .out_valid         (out_valid),
    .out_shoulder_angle(out_shoulder_angle),
    .out_elbow_angle   (out_elbow_angle),
    .out_reachable     (out_reachable),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor division by a power of two on signed 64-bit values.
  function automatic longint floor_shift(input longint v, input int n);
    return v >>> n;
  endfunction

  // Integer square root by the bit-pair method.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: the angle of (vx, vy) in Q.30 radians.
  function automatic longint vector_angle(input longint vx, input longint vy);
    longint z;
    longint dx;
    longint dy;
    if (vx == 0 && vy == 0) return 0;
    z = 0;
    // A vector in the left half plane is turned by half a revolution first.
    if (vx < 0) begin
      z  = (vy >= 0) ? PI_FIXED : -PI_FIXED;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = floor_shift(vy, i);
      dy = floor_shift(vx, i);
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + longint'(atan_q30(i));
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - longint'(atan_q30(i));
      end
    end
    return z;
  endfunction

  // Rounds a Q.30 angle to Q3.20 or Q2.20 and clamps it to the output range.
  function automatic longint angle_to_output(input longint z, input longint lo);
    longint r;
    r = floor_shift(z + 512, 10);
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < lo) r = lo;
    return r;
  endfunction

  // Solves the arm for one target with the current link lengths.
  function automatic joint_sol_t solve_arm(input logic signed [XW-1:0] tx,
                                           input logic signed [XW-1:0] ty);
    joint_sol_t sol;
    longint x;
    longint y;
    longint l1;
    longint l2;
    longint num;
    longint den;
    longint unsigned rem;
    longint unsigned quo;
    longint c;
    longint s;
    longint k1;
    longint k2;
    longint px;
    longint py;
    longint mag_num;
    x  = tx;
    y  = ty;
    l1 = len_shoulder_link;
    l2 = len_elbow_link;
    num = x * x + y * y - l1 * l1 - l2 * l2;
    den = 2 * l1 * l2;
    mag_num = (num < 0) ? -num : num;
    sol.shoulder = '0;
    sol.elbow    = '0;
    sol.reach    = 1'b0;
    // Out of the workspace, or a zero link length: zero angles, not reachable.
    if (den == 0 || mag_num > den) return sol;
    // |cos2| in Q.30 by restoring division.
    rem = mag_num;
    quo = 0;
    if (rem >= den) begin
      quo = 1;
      rem = rem - den;
    end
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    c = (num < 0) ? -longint'(quo) : longint'(quo);
    s = longint'(int_sqrt(longint'(UNIT_Q30 * UNIT_Q30) - c * c));
    sol.elbow = ELW'(angle_to_output(vector_angle(c, s), 0));
    k1 = l1 * 16384 + floor_shift(l2 * c, 16);
    k2 = floor_shift(l2 * s, 16);
    px = k1 * x + k2 * y;
    py = k1 * y - k2 * x;
    // Normalize so that both components fit the CORDIC datapath.
    while (px >= (64'sd1 <<< 40) || px <= -(64'sd1 <<< 40) ||
           py >= (64'sd1 <<< 40) || py <= -(64'sd1 <<< 40)) begin
      px = floor_shift(px, 1);
      py = floor_shift(py, 1);
    end
    sol.shoulder = SHW'(angle_to_output(vector_angle(px, py), -ANGLE_LIMIT));
    sol.reach    = 1'b1;
    return sol;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Result checker: every strobe must match the oldest pending solution.
  always @(posedge clk) begin
    joint_sol_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_solutions.size() == 0) begin
        report_mismatch("unexpected result, reachable", out_reachable, -1);
      end else begin
        want = pending_solutions.pop_front();
        solutions_checked++;
        if (!want.reach) unreachable_seen++;
        if (out_shoulder_angle !== want.shoulder)
          report_mismatch("shoulder_angle", out_shoulder_angle, want.shoulder);
        if (out_elbow_angle !== want.elbow)
          report_mismatch("elbow_angle", out_elbow_angle, want.elbow);
        if (out_reachable !== want.reach)
          report_mismatch("reachable", out_reachable, want.reach);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Writes one link length through the APB port, setup then access cycle.
  task automatic write_link(input logic [2:0] addr, input logic [LW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_L1) len_shoulder_link = value;
    else len_elbow_link = value;
    settings_used++;
  endtask

  // Waits for every owed solution, plus slack for work still in the pipeline.
  task automatic drain_pipeline();
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Issues one request. With idling enabled, about one cycle in five is left
  // empty before it. The start line stays high across back-to-back requests.
  task automatic send_target(input logic signed [XW-1:0] tx, input logic signed [XW-1:0] ty,
                             input bit idle_ok);
    if (idle_ok) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    in_target_x <= tx;
    in_target_y <= ty;
    do @(posedge clk); while (busy);
    // The prediction is queued at the accepting edge itself.
    pending_solutions.push_back(solve_arm(tx, ty));
    requests_sent++;
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // A random target scaled to a reach that the current links can span, so
  // that most targets land in the workspace; the rest cover the full field.
  task automatic send_random_target(input bit idle_ok);
    longint reach_len;
    longint r;
    int     sel;
    logic signed [XW-1:0] tx;
    logic signed [XW-1:0] ty;
    reach_len = longint'(len_shoulder_link) + longint'(len_elbow_link);
    if (reach_len > 8388607) reach_len = 8388607;
    sel = $urandom_range(99);
    if (sel < 75) begin
      r  = (reach_len * 2) / 3 + 1;
      tx = XW'(longint'($urandom_range(32'(2 * r))) - r);
      ty = XW'(longint'($urandom_range(32'(2 * r))) - r);
    end else begin
      tx = XW'($urandom);
      ty = XW'($urandom);
    end
    send_target(tx, ty, idle_ok);
  endtask

  target_row_t target_table[$];
  joint_sol_t  typed_sol;
  logic [LW-1:0] link_settings[6][2];

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_target_x = '0;
    in_target_y = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count        = 0;
    cycle_count       = 0;
    solutions_checked = 0;
    unreachable_seen  = 0;
    requests_sent     = 0;
    settings_used     = 0;
    len_shoulder_link = 23'd65536;
    len_elbow_link    = 23'd65536;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed targets with the reset links of 1.0. Unreachable rows carry
    // their answer; the others are checked against the predictor.
    target_table = '{
      '{24'sd0,        24'sd0,        EXP_NONE},  // folded arm, zero shoulder vector
      '{24'sd131072,   24'sd0,        EXP_NONE},  // fully stretched along x
      '{24'sd0,        24'sd131072,   EXP_NONE},  // fully stretched along y
      '{-24'sd131072,  24'sd0,        EXP_NONE},  // stretched toward minus x
      '{24'sd0,        -24'sd131072,  EXP_NONE},
      '{24'sd65536,    24'sd65536,    EXP_NONE},
      '{-24'sd65536,   -24'sd65536,   EXP_NONE},
      '{-24'sd65536,   24'sd1,        EXP_NONE},
      '{-24'sd65536,   -24'sd1,       EXP_NONE},
      '{24'sd92681,    24'sd0,        EXP_NONE},
      '{24'sd131073,   24'sd0,        EXP_ZERO},  // just beyond reach
      '{24'sh7FFFFF,   24'sh7FFFFF,   EXP_ZERO},  // field extremes
      '{-24'sh800000,  -24'sh800000,  EXP_ZERO},
      '{24'sh7FFFFF,   -24'sh800000,  EXP_ZERO},
      '{-24'sh800000,  24'sh7FFFFF,   EXP_ZERO},
      '{24'sh555555,   -24'sh2AAAAB,  EXP_ZERO}
    };
    foreach (target_table[i]) begin
      send_target(target_table[i].x, target_table[i].y, 1'b0);
      if (target_table[i].typed == EXP_ZERO) begin
        typed_sol.shoulder = '0;
        typed_sol.elbow    = '0;
        typed_sol.reach    = 1'b0;
        pending_solutions[pending_solutions.size() - 1] = typed_sol;
      end
    end
    stop_sending();
    drain_pipeline();

    // A zero link length makes every target unreachable.
    write_link(ADDR_L1, 23'd0);
    send_target(24'sd0, 24'sd0, 1'b0);
    send_target(24'sd65536, 24'sd0, 1'b0);
    stop_sending();
    drain_pipeline();

    // Link settings swept in phases, the extremes among them.
    link_settings = '{
      '{23'd65536,   23'd65536},
      '{23'd1,       23'd1},
      '{23'h7FFFFF,  23'h7FFFFF},
      '{23'h7FFFFF,  23'd1},
      '{23'd98304,   23'd40000},
      '{23'd3000000, 23'd5000000}
    };
    for (int p = 0; p < 6; p++) begin
      write_link(ADDR_L1, link_settings[p][0]);
      write_link(ADDR_L2, link_settings[p][1]);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        // The first phase runs back to back with no idle cycles.
        send_random_target(p != 0);
        // Once, the sender holds off until everything owed has come back.
        if (p == 3 && n == 100) begin
          stop_sending();
          while (pending_solutions.size() != 0) @(posedge clk);
        end
      end
      stop_sending();
      drain_pipeline();
    end

    $display("Sent %0d requests over %0d link writes; %0d results checked, %0d unreachable.",
             requests_sent, settings_used, solutions_checked, unreachable_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
